>>> design/frame_fenced_slot_bump_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// frame_fenced_slot_bump_allocator_unit_assert
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef FRAME_FENCED_SLOT_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define FRAME_FENCED_SLOT_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
// implication checked on every clock, off during reset
`define FFSB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FFSB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/ffsb_pkg.sv
// ----------------------------------------------------------------------------
// ffsb_pkg
// Types and constants of the page ring bump allocator.
// ----------------------------------------------------------------------------
package ffsb_pkg;
  localparam int unsigned OffW = 25;
  localparam int unsigned AlnW = 13;
  localparam int unsigned CntW = 32;
  localparam int unsigned FrmW = 64;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_RESERVE = 3'd1,
    OP_MARK   = 3'd2,
    OP_RECYCLE = 3'd3,
    OP_CANRES = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REG_VCAP = 2'd0,
    REG_ICAP = 2'd1,
    REG_DALN = 2'd2,
    REG_FIF  = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RETIRE,
    ST_PICK,
    ST_ALIGN,
    ST_FIT,
    ST_ALIGN2,
    ST_FIT2,
    ST_DONE
  } state_e;

  // remainder unit request / response
  typedef struct packed {
    logic            start;
    logic [OffW-1:0] value;
    logic [AlnW-1:0] align;
  } rem_req_t;

  typedef struct packed {
    logic            done;
    logic [OffW:0]   rounded;
  } rem_rsp_t;
endpackage

>>> design/frame_fenced_slot_bump_allocator_unit.sv
// Page ring bump allocator with frame fences; one op at a time, busy high meanwhile.
// Mark, unused op and zero-size reserve go straight to the result strobe; recycle
// runs the pick scan over 1..PAGE_COUNT pages; frame start takes frame mod PAGE_COUNT
// a nibble per step, then the retire scan and pick scan; reserve uses the round-up unit
// once, fit test twice. Next op is taken at the edge ending the strobe; no stall.
// Reset (rst_ni low, async) restores register defaults, clears marks, offsets, counters.
// ----------------------------------------------------------------------------
// frame_fenced_slot_bump_allocator_unit
// Sequencer, page state and registers around a shared round-up unit.
// ----------------------------------------------------------------------------
module frame_fenced_slot_bump_allocator_unit #(
  parameter int unsigned PAGE_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [63:0] frame_number_i,
  input  logic        is_vertex_i,
  input  logic [24:0] size_bytes_i,
  input  logic [12:0] align_req_i,
  input  logic [24:0] second_size_bytes_i,
  input  logic [12:0] second_align_req_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [24:0] offset_o,
  output logic [5:0]  slot_index_o,
  output logic [24:0] vertex_level_o,
  output logic [24:0] index_level_o,
  output logic [24:0] vertex_peak_o,
  output logic [24:0] index_peak_o,
  output logic [31:0] vertex_overflow_count_o,
  output logic [31:0] index_overflow_count_o,
  output logic [31:0] recycle_count_o,
  output logic [31:0] forced_wait_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffsb_pkg::*;

  localparam int unsigned PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned XW = PW + 4;

  state_e st_q, st_d;
  logic [OffW-1:0] vcap_q, icap_q;
  logic [AlnW-1:0] daln_q;
  logic [7:0]      fif_q;

  logic [PAGE_COUNT-1:0] busy_q;
  logic [FrmW-1:0] subm_q [PAGE_COUNT];
  logic [PW-1:0]   cur_q, want_q, scan_q;
  logic [PW:0]     cnt_q;
  logic [PW-1:0]   mod_q;
  logic [3:0]      mcnt_q;
  logic [FrmW-1:0] latest_q;
  logic [OffW-1:0] voff_q, ioff_q, vhi_q, ihi_q;
  logic [CntW-1:0] vovf_q, iovf_q, recy_q, wait_q;

  logic [2:0]      op_q;
  logic            vtx_q;
  logic [OffW-1:0] sz_q, sz2_q;
  logic [AlnW-1:0] al_q, al2_q;
  logic            ok_q, a_ok_q, done_q;
  logic [OffW-1:0] res_q;

  rem_req_t req;
  rem_rsp_t rsp;
  ffsb_round u_round (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  logic wr;
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_VCAP: prdata = 32'(vcap_q);
      REG_ICAP: prdata = 32'(icap_q);
      REG_DALN: prdata = 32'(daln_q);
      REG_FIF:  prdata = 32'(fif_q);
      default:  prdata = '0;
    endcase
  end

  logic accept;
  assign accept = start & ~busy;
  assign busy = (st_q != ST_IDLE);

  // shared fit check against the rounded start
  logic [OffW-1:0] fit_cap, fit_sz;
  logic            fit_ok;
  always_comb begin
    fit_cap = (st_q == ST_FIT2 || !(vtx_q || op_q == OP_CANRES)) ? icap_q : vcap_q;
    if (st_q == ST_FIT && op_q == OP_RESERVE && !vtx_q) fit_cap = icap_q;
    fit_sz = (st_q == ST_FIT2) ? sz2_q : sz_q;
    fit_ok = (rsp.rounded <= (OffW + 1)'(fit_cap)) &&
             ((OffW + 1)'(fit_sz) <= (OffW + 1)'(fit_cap) - rsp.rounded);
  end

  logic [AlnW-1:0] eff_al, eff_al2;
  assign eff_al  = (al_q  != '0) ? al_q  : daln_q;
  assign eff_al2 = (al2_q != '0) ? al2_q : daln_q;

  logic [FrmW-1:0] age;
  logic [7:0]      lat;
  assign lat = (fif_q != '0) ? fif_q : 8'd1;
  assign age = latest_q - subm_q[scan_q];

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (accept) begin
        case (opcode_i)
          OP_BEGIN:   st_d = ST_MOD;
          OP_RECYCLE: st_d = ST_PICK;
          OP_RESERVE: st_d = (size_bytes_i != '0) ? ST_ALIGN : ST_DONE;
          OP_CANRES:  st_d = ST_ALIGN;
          default:    st_d = ST_DONE;
        endcase
      end
      ST_MOD:    if (mcnt_q == 4'd15) st_d = ST_RETIRE;
      ST_RETIRE: if (cnt_q == (PW + 1)'(PAGE_COUNT - 1)) st_d = ST_PICK;
      ST_PICK:   if (!busy_q[scan_q] || cnt_q == (PW + 1)'(PAGE_COUNT - 1)) st_d = ST_DONE;
      ST_ALIGN:  st_d = ST_FIT;
      ST_FIT:    if (rsp.done) st_d = (op_q == OP_CANRES) ? ST_ALIGN2 : ST_DONE;
      ST_ALIGN2: st_d = ST_FIT2;
      ST_FIT2:   if (rsp.done) st_d = ST_DONE;
      ST_DONE:   st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // remainder unit requests
  always_comb begin
    req.start = 1'b0;
    req.value = (op_q == OP_CANRES || vtx_q) ? voff_q : ioff_q;
    req.align = eff_al;
    case (st_q)
      ST_ALIGN: req.start = 1'b1;
      ST_ALIGN2: begin
        req.start = 1'b1; req.value = ioff_q; req.align = eff_al2;
      end
      default: ;
    endcase
  end

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    nxt = (32'(p) + 1 >= PAGE_COUNT) ? '0 : PW'(32'(p) + 1);
  endfunction

  // one nibble of frame mod PAGE_COUNT: (acc * 16 + nib) reduced by compare and subtract
  function automatic logic [PW-1:0] mod_step(input logic [PW-1:0] acc, input logic [3:0] nib);
    logic [XW-1:0] x;
    x = {acc, nib};
    for (int k = 3; k >= 0; k--) begin
      if (x >= XW'(PAGE_COUNT << k)) x = x - XW'(PAGE_COUNT << k);
    end
    mod_step = x[PW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      vcap_q <= 25'd1048576; icap_q <= 25'd262144; daln_q <= 13'd16; fif_q <= 8'd2;
      busy_q <= '0;
      for (int i = 0; i < PAGE_COUNT; i++) subm_q[i] <= '1;
      cur_q <= '0; want_q <= '0; scan_q <= '0; cnt_q <= '0;
      mod_q <= '0; mcnt_q <= '0;
      latest_q <= '0; voff_q <= '0; ioff_q <= '0; vhi_q <= '0; ihi_q <= '0;
      vovf_q <= '0; iovf_q <= '0; recy_q <= '0; wait_q <= '0;
      done_q <= 1'b0; ok_q <= 1'b0; res_q <= '0; a_ok_q <= 1'b0;
      op_q <= '0; vtx_q <= 1'b0; sz_q <= '0; sz2_q <= '0; al_q <= '0; al2_q <= '0;
    end else begin
      st_q <= st_d;
      done_q <= (st_q == ST_DONE);
      if (wr) begin
        case (paddr[3:2])
          REG_VCAP: vcap_q <= pwdata[OffW-1:0];
          REG_ICAP: icap_q <= pwdata[OffW-1:0];
          REG_DALN: daln_q <= pwdata[AlnW-1:0];
          REG_FIF:  fif_q  <= pwdata[7:0];
          default: ;
        endcase
      end
      case (st_q)
        ST_IDLE: if (accept) begin
          op_q <= opcode_i; vtx_q <= is_vertex_i; sz_q <= size_bytes_i;
          sz2_q <= second_size_bytes_i; al_q <= align_req_i; al2_q <= second_align_req_i;
          ok_q <= (opcode_i == OP_MARK); res_q <= '0; cnt_q <= '0;
          scan_q <= (opcode_i == OP_RECYCLE) ? nxt(cur_q) : '0;
          case (opcode_i)
            OP_BEGIN: begin
              latest_q <= frame_number_i; mod_q <= '0; mcnt_q <= '0;
            end
            OP_MARK: begin
              busy_q[cur_q] <= 1'b1; subm_q[cur_q] <= latest_q;
            end
            OP_RECYCLE: want_q <= nxt(cur_q);
            default: ;
          endcase
        end
        ST_MOD: begin
          // most significant nibble first
          mod_q <= mod_step(mod_q, latest_q[{~mcnt_q, 2'b00} +: 4]);
          mcnt_q <= mcnt_q + 1'b1;
        end
        ST_RETIRE: begin
          if (busy_q[scan_q] && latest_q >= subm_q[scan_q] && age >= FrmW'(lat)) begin
            busy_q[scan_q] <= 1'b0; subm_q[scan_q] <= '1;
          end
          if (cnt_q == (PW + 1)'(PAGE_COUNT - 1)) begin
            cnt_q <= '0;
            want_q <= mod_q;
            scan_q <= mod_q;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            scan_q <= nxt(scan_q);
          end
        end
        ST_PICK: begin
          if (!busy_q[scan_q]) begin
            cur_q <= scan_q; voff_q <= '0; ioff_q <= '0; ok_q <= 1'b1;
            if (op_q == OP_RECYCLE) recy_q <= recy_q + 1'b1;
          end else if (cnt_q == (PW + 1)'(PAGE_COUNT - 1)) begin
            wait_q <= wait_q + 1'b1; busy_q <= '0;
            for (int i = 0; i < PAGE_COUNT; i++) subm_q[i] <= '1;
            cur_q <= want_q; voff_q <= '0; ioff_q <= '0; ok_q <= 1'b1;
            if (op_q == OP_RECYCLE) recy_q <= recy_q + 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1; scan_q <= nxt(scan_q);
          end
        end
        ST_FIT: if (rsp.done) begin
          if (op_q == OP_CANRES) a_ok_q <= fit_ok;
          else if (fit_ok) begin
            ok_q <= 1'b1; res_q <= rsp.rounded[OffW-1:0];
            if (vtx_q) begin
              voff_q <= rsp.rounded[OffW-1:0] + sz_q;
              if (rsp.rounded[OffW-1:0] + sz_q > vhi_q) vhi_q <= rsp.rounded[OffW-1:0] + sz_q;
            end else begin
              ioff_q <= rsp.rounded[OffW-1:0] + sz_q;
              if (rsp.rounded[OffW-1:0] + sz_q > ihi_q) ihi_q <= rsp.rounded[OffW-1:0] + sz_q;
            end
          end else if (vtx_q) vovf_q <= vovf_q + 1'b1;
          else iovf_q <= iovf_q + 1'b1;
        end
        ST_FIT2: if (rsp.done) ok_q <= a_ok_q & fit_ok;
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign ok_o = ok_q;
  assign offset_o = res_q;
  assign slot_index_o = 6'(cur_q);
  assign vertex_level_o = voff_q;
  assign index_level_o = ioff_q;
  assign vertex_peak_o = vhi_q;
  assign index_peak_o = ihi_q;
  assign vertex_overflow_count_o = vovf_q;
  assign index_overflow_count_o = iovf_q;
  assign recycle_count_o = recy_q;
  assign forced_wait_count_o = wait_q;
endmodule

>>> design/ffsb_round.sv
// ----------------------------------------------------------------------------
// ffsb_round
// Bit-serial restoring remainder; rounds a value up to an alignment.
// ----------------------------------------------------------------------------
module ffsb_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffsb_pkg::rem_req_t req_i,
  output ffsb_pkg::rem_rsp_t rsp_o
);
  import ffsb_pkg::*;

  localparam int unsigned StepW = $clog2(OffW + 1);

  logic [OffW-1:0] val_q, val_d, dvd_q, dvd_d;
  logic [AlnW-1:0] aln_q, aln_d;
  logic [AlnW:0]   rem_q, rem_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [AlnW:0]   shifted;
  logic [OffW:0]   rounded_c;

  always_comb begin
    val_d = val_q; dvd_d = dvd_q; aln_d = aln_q; rem_d = rem_q;
    cnt_d = cnt_q; run_d = run_q; done_d = 1'b0;
    shifted = {rem_q[AlnW-1:0], dvd_q[OffW-1]};
    if (req_i.start) begin
      val_d = req_i.value; dvd_d = req_i.value; aln_d = req_i.align;
      rem_d = '0; cnt_d = StepW'(OffW); run_d = 1'b1;
    end else if (run_q) begin
      dvd_d = {dvd_q[OffW-2:0], 1'b0};
      rem_d = (shifted >= {1'b0, aln_q}) ? shifted - {1'b0, aln_q} : shifted;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_comb begin
    if (aln_q <= AlnW'(1) || rem_q == '0) rounded_c = {1'b0, val_q};
    else rounded_c = {1'b0, val_q} + (OffW + 1)'(aln_q) - (OffW + 1)'(rem_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; dvd_q <= dvd_d; aln_q <= aln_d; rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rounded = rounded_c;
endmodule

>>> design/ffsb_checker.sv
// ----------------------------------------------------------------------------
// ffsb_checker
// Port-level checks of the allocator.
// ----------------------------------------------------------------------------
`include "frame_fenced_slot_bump_allocator_unit_assert.svh"
module ffsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        ok_o,
  input logic [24:0] offset_o,
  input logic [31:0] recycle_count_o
);
  // a word is reported only while no op is in flight
  `FFSB_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, !busy)
  // accepted op makes the unit busy
  `FFSB_ASSERT_NXT(a_acc_busy, clk_i, rst_ni, start && !busy, busy)
  // failed ops report no offset
  `FFSB_ASSERT_IMP(a_fail_off, clk_i, rst_ni, done_o && !ok_o, offset_o == '0)
  // recycle counter changes only while an op is in flight
  `FFSB_ASSERT_NXT(a_recy, clk_i, rst_ni, !busy, $stable(recycle_count_o))
endmodule

bind frame_fenced_slot_bump_allocator_unit ffsb_checker u_ffsb_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the page ring bump allocator against an in-bench model of its pages,
// fences, region offsets and counters: directed ops first, then random ops
// under several register settings, with random command-side gaps in all but the last setting.
// ----------------------------------------------------------------------------
import ffsb_pkg::*;

typedef struct {
  bit        ok;
  bit [24:0] offset;
  bit [5:0]  slot;
  bit [24:0] vused;
  bit [24:0] iused;
  bit [24:0] vpeak;
  bit [24:0] ipeak;
  bit [31:0] vovf;
  bit [31:0] iovf;
  bit [31:0] recycles;
  bit [31:0] waits;
} alloc_word_t;

class alloc_scoreboard;
  localparam int PAGES = 4;
  bit [24:0] vcap, icap;
  bit [12:0] dalign;
  bit [7:0]  fif;
  bit        busy_mark[PAGES];
  bit [63:0] fence[PAGES];
  bit [5:0]  cur_page;
  bit [63:0] last_frame;
  bit [24:0] voff, ioff, vhigh, ihigh;
  bit [31:0] vovf, iovf, recycles, waits;
  alloc_word_t expected_q[$];
  int mismatches;

  function new();
    vcap = 25'd1048576; icap = 25'd262144; dalign = 13'd16; fif = 8'd2;
    for (int p = 0; p < PAGES; p++) begin
      busy_mark[p] = 0;
      fence[p] = '1;
    end
    cur_page = 0; last_frame = 0;
    voff = 0; ioff = 0; vhigh = 0; ihigh = 0;
    vovf = 0; iovf = 0; recycles = 0; waits = 0;
    mismatches = 0;
  endfunction

  function void write_reg(reg_e r, bit [31:0] v);
    case (r)
      REG_VCAP: vcap = v[24:0];
      REG_ICAP: icap = v[24:0];
      REG_DALN: dalign = v[12:0];
      REG_FIF:  fif = v[7:0];
      default: ;
    endcase
  endfunction

  function void select(int p);
    cur_page = 6'(p); voff = 0; ioff = 0;
  endfunction

  function void pick(int want);
    for (int s = 0; s < PAGES; s++) begin
      if (!busy_mark[(want + s) % PAGES]) begin
        select((want + s) % PAGES);
        return;
      end
    end
    waits++;
    for (int p = 0; p < PAGES; p++) begin
      busy_mark[p] = 0;
      fence[p] = '1;
    end
    select(want);
  endfunction

  function bit fits(bit [24:0] off, bit [24:0] cap, bit [24:0] bytes, bit [12:0] align,
                    output longint unsigned start);
    longint unsigned a;
    longint unsigned r;
    a = (align != 0) ? align : dalign;
    start = off;
    if (a > 1) begin
      r = off % a;
      if (r != 0) start = off + (a - r);
    end
    return start <= cap && bytes <= cap - start;
  endfunction

  function void note(bit [2:0] op, bit [63:0] frame, bit vtx, bit [24:0] size,
                     bit [12:0] align, bit [24:0] size2, bit [12:0] align2);
    alloc_word_t w;
    longint unsigned st, st2, lat;
    bit a, b;
    w.ok = 0; w.offset = 0;
    case (op)
      OP_BEGIN: begin
        lat = (fif != 0) ? fif : 1;
        last_frame = frame;
        for (int p = 0; p < PAGES; p++)
          if (busy_mark[p] && frame >= fence[p] && frame - fence[p] >= lat) begin
            busy_mark[p] = 0;
            fence[p] = '1;
          end
        pick(int'(frame % PAGES));
        w.ok = 1;
      end
      OP_RESERVE: begin
        if (size != 0) begin
          if (fits(vtx ? voff : ioff, vtx ? vcap : icap, size, align, st)) begin
            if (vtx) begin
              voff = 25'(st + size);
              if (voff > vhigh) vhigh = voff;
            end else begin
              ioff = 25'(st + size);
              if (ioff > ihigh) ihigh = ioff;
            end
            w.offset = 25'(st);
            w.ok = 1;
          end else if (vtx) vovf++;
          else iovf++;
        end
      end
      OP_MARK: begin
        busy_mark[cur_page % PAGES] = 1;
        fence[cur_page % PAGES] = last_frame;
        w.ok = 1;
      end
      OP_RECYCLE: begin
        pick((cur_page + 1) % PAGES);
        recycles++;
        w.ok = 1;
      end
      OP_CANRES: begin
        a = fits(voff, vcap, size, align, st);
        b = fits(ioff, icap, size2, align2, st2);
        w.ok = a && b;
      end
      default: ;
    endcase
    w.slot = cur_page; w.vused = voff; w.iused = ioff; w.vpeak = vhigh; w.ipeak = ihigh;
    w.vovf = vovf; w.iovf = iovf; w.recycles = recycles; w.waits = waits;
    expected_q.push_back(w);
  endfunction

  function void field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", name, e, a);
    end
  endfunction

  function void check(alloc_word_t got);
    alloc_word_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: result word with nothing expected");
      return;
    end
    e = expected_q.pop_front();
    field("ok", e.ok, got.ok);
    field("offset", e.offset, got.offset);
    field("slot_index", e.slot, got.slot);
    field("vertex_level", e.vused, got.vused);
    field("index_level", e.iused, got.iused);
    field("vertex_peak", e.vpeak, got.vpeak);
    field("index_peak", e.ipeak, got.ipeak);
    field("vertex_overflow_count", e.vovf, got.vovf);
    field("index_overflow_count", e.iovf, got.iovf);
    field("recycle_count", e.recycles, got.recycles);
    field("forced_wait_count", e.waits, got.waits);
  endfunction
endclass

module tb_top;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  opcode_i = '0;
  logic [63:0] frame_number_i = '0;
  logic        is_vertex_i = 0;
  logic [24:0] size_bytes_i = '0;
  logic [12:0] align_req_i = '0;
  logic [24:0] second_size_bytes_i = '0;
  logic [12:0] second_align_req_i = '0;
  logic        done_o, ok_o;
  logic [24:0] offset_o, vertex_level_o, index_level_o, vertex_peak_o, index_peak_o;
  logic [5:0]  slot_index_o;
  logic [31:0] vertex_overflow_count_o, index_overflow_count_o;
  logic [31:0] recycle_count_o, forced_wait_count_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard alloc_sb = new();
  int unsigned cycles = 0;
  bit [63:0]   frame_now = 0;
  bit          gaps_on = 1;

  frame_fenced_slot_bump_allocator_unit dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result words are checked at the edge that ends their strobe cycle
  always @(posedge clk_i) begin
    alloc_word_t got;
    if (rst_ni && done_o) begin
      got.ok = ok_o; got.offset = offset_o; got.slot = slot_index_o;
      got.vused = vertex_level_o; got.iused = index_level_o;
      got.vpeak = vertex_peak_o; got.ipeak = index_peak_o;
      got.vovf = vertex_overflow_count_o; got.iovf = index_overflow_count_o;
      got.recycles = recycle_count_o; got.waits = forced_wait_count_o;
      alloc_sb.check(got);
    end
  end

  task automatic send_op(bit [2:0] op, bit [63:0] frame, bit vtx, bit [24:0] size,
                         bit [12:0] align, bit [24:0] size2 = 0, bit [12:0] align2 = 0);
    int gap;
    opcode_i <= op; frame_number_i <= frame; is_vertex_i <= vtx;
    size_bytes_i <= size; align_req_i <= align;
    second_size_bytes_i <= size2; second_align_req_i <= align2;
    start <= 1;
    do @(posedge clk_i); while (busy);
    alloc_sb.note(op, frame, vtx, size, align, size2, align2);
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (alloc_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e r, bit [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    alloc_sb.write_reg(r, v);
    @(posedge clk_i);
  endtask

  task automatic configure(bit [31:0] vc, bit [31:0] ic, bit [31:0] da, bit [31:0] fi);
    apb_write(REG_VCAP, vc);
    apb_write(REG_ICAP, ic);
    apb_write(REG_DALN, da);
    apb_write(REG_FIF, fi);
    @(posedge clk_i);
  endtask

  function automatic bit [12:0] rand_align();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 16;
      4: return 4096;
      5: return 13'd1 << $urandom_range(0, 12);
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic bit [24:0] rand_size(bit [24:0] cap);
    case ($urandom_range(0, 19))
      0: return 25'd16777216;
      1: return 0;
      2, 3: return 25'($urandom_range(0, cap));
      default: return 25'($urandom_range(1, 512));
    endcase
  endfunction

  task automatic random_ops(int n);
    int k;
    bit [2:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 10) op = OP_BEGIN;
      else if (k < 52) op = OP_RESERVE;
      else if (k < 67) op = OP_MARK;
      else if (k < 77) op = OP_RECYCLE;
      else if (k < 94) op = OP_CANRES;
      else op = 3'($urandom_range(5, 7));
      if (op == OP_BEGIN) begin
        // mostly frames marching forward, now and then a jump anywhere
        if ($urandom_range(0, 19) == 0) frame_now = {$urandom, $urandom};
        else frame_now = frame_now + $urandom_range(0, 3);
        if (frame_now == '1) frame_now = frame_now - 1;
      end
      send_op(op, frame_now, 1'($urandom_range(0, 1)), rand_size(alloc_sb.vcap), rand_align(),
              rand_size(alloc_sb.icap), rand_align());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset settings, page fences, forced wait, odd opcodes
    send_op(OP_BEGIN, 0, 0, 0, 0);
    send_op(OP_RESERVE, 0, 1, 1, 0);
    send_op(OP_RESERVE, 0, 1, 100, 0);
    send_op(OP_RESERVE, 0, 0, 0, 0);
    send_op(OP_RESERVE, 0, 1, 25'd16777216, 0);
    send_op(OP_RESERVE, 0, 0, 100, 4096);
    send_op(OP_RESERVE, 0, 0, 262144, 1);
    send_op(OP_CANRES, 0, 0, 64, 4096, 64, 0);
    send_op(OP_CANRES, 0, 0, 25'd16777216, 1, 1, 1);
    send_op(OP_MARK, 0, 0, 0, 0);
    send_op(OP_BEGIN, 1, 0, 0, 0);
    send_op(OP_MARK, 0, 0, 0, 0);
    send_op(OP_BEGIN, 5, 0, 0, 0);
    for (int i = 0; i < 4; i++) begin
      send_op(OP_MARK, 0, 0, 0, 0);
      send_op(OP_RECYCLE, 0, 0, 0, 0);
    end
    send_op(OP_BEGIN, 5, 0, 0, 0);
    send_op(3'd5, 0, 1, 8, 8);
    send_op(3'd6, 0, 1, 8, 8);
    send_op(3'd7, 0, 1, 8, 8);
    send_op(OP_BEGIN, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0);
    send_op(OP_MARK, 0, 0, 0, 0);
    drain();

    configure(32'd16777216, 32'd16777216, 32'd4096, 32'd255);
    random_ops(200);
    drain();
    configure(32'd1, 32'd1, 32'd0, 32'd0);
    random_ops(150);
    drain();
    configure(32'd4096, 32'd1024, 32'd1, 32'd1);
    random_ops(200);
    drain();
    configure(32'd65536, 32'd8192, $urandom_range(0, 4096), 32'd3);
    gaps_on = 0;
    random_ops(250);
    drain();

    if (alloc_sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
